[rtl/core/dgpp_pkg.sv]
package dgpp_pkg;

	localparam int FRAC_BITS    = 16;
	localparam int SIZE_W       = 32;
	localparam int ACC_W        = 48;
	localparam int MAX_ELEMENTS = 4096;
	localparam int IDX_W        = $clog2(MAX_ELEMENTS);
	localparam int CNT_W        = IDX_W + 1;
	localparam int MUL_W        = 9;
	localparam int PROD_W       = ACC_W + MUL_W;
	localparam int DIGIT_W      = 8;
	localparam int QD_W         = ((PROD_W + DIGIT_W - 1) / DIGIT_W) * DIGIT_W;
	localparam int QD_STEPS     = QD_W / DIGIT_W;
	localparam int QD_CNT_W     = $clog2(QD_STEPS);
	localparam int DIV_CNT_W    = $clog2(ACC_W + 1);
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 13;

	localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};

	typedef enum logic [1:0] {
		OP_LOAD     = 2'd0,
		OP_INNER    = 2'd1,
		OP_BOUNDARY = 2'd2,
		OP_FINISH   = 2'd3
	} op_t;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_ZERO_SIZE = 2'd1;
	localparam logic [1:0] ST_BAD_INDEX = 2'd2;
	localparam logic [1:0] ST_SATURATED = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_DIM   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ORDER = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_COUNT = 2'd2;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

[rtl/core/dgpp_ram.sv]
module dgpp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rd_q <= mem_q[raddr];
	end

	assign rdata = rd_q;

endmodule

[rtl/core/dgpp_divider.sv]
// Restoring divider, one quotient bit per cycle.
module dgpp_divider (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [dgpp_pkg::ACC_W-1:0]  dividend,
	input  logic [dgpp_pkg::SIZE_W-1:0] divisor,
	output dgpp_pkg::div_stat_t         stat,
	output logic [dgpp_pkg::ACC_W-1:0]  quotient
);

	logic                           busy_q;
	logic                           done_q;
	logic [dgpp_pkg::DIV_CNT_W-1:0] cnt_q;
	logic [dgpp_pkg::SIZE_W-1:0]    rem_q;
	logic [dgpp_pkg::SIZE_W-1:0]    dvs_q;
	logic [dgpp_pkg::ACC_W-1:0]     qsh_q;
	logic [dgpp_pkg::SIZE_W:0]      trial;
	logic [dgpp_pkg::SIZE_W:0]      diff;
	logic                           ge;

	assign trial = {rem_q, qsh_q[dgpp_pkg::ACC_W-1]};
	assign ge    = trial >= {1'b0, dvs_q};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == dgpp_pkg::DIV_CNT_W'(dgpp_pkg::ACC_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvs_q <= divisor;
			qsh_q <= dividend;
		end else if (busy_q) begin
			rem_q <= ge ? diff[dgpp_pkg::SIZE_W-1:0] : trial[dgpp_pkg::SIZE_W-1:0];
			qsh_q <= {qsh_q[dgpp_pkg::ACC_W-2:0], ge};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = qsh_q;

endmodule

[rtl/core/dg_penalty_parameter_max_top.sv]
// A load is taken without leaving idle. A boundary edge holds the input channel while its
// neighbour takes one bit-serial 48-bit division (one quotient bit a cycle), and an inner
// edge does so for each of its two neighbours; a zero element size skips the division.
// A finish walks all 4096 accumulators, each through read, multiply, eight 8-bit division
// digits and compare, then emits; one item is worked at a time.
// Reset is asynchronous and active low; after reset a clearing pass zeroes all 4096 entries of
// the accumulator memory, during which no transaction is accepted on the input channel.
module dg_penalty_parameter_max_top (
	input  logic                            clk,
	input  logic                            arst_n,
	// input channel
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [1:0]                      op,
	input  logic [11:0]                     elem_a,
	input  logic [11:0]                     elem_b,
	input  logic [31:0]                     size_value,
	// result channel
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [47:0]                     penalty,
	output logic [1:0]                      status,
	// configuration channel
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [dgpp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [dgpp_pkg::CFG_DATA_W-1:0] cfg_data
);

	typedef enum logic [11:0] {
		S_CLEAR = 12'b000000000001,
		S_IDLE  = 12'b000000000010,
		S_RD    = 12'b000000000100,
		S_DIVS  = 12'b000000001000,
		S_DIVW  = 12'b000000010000,
		S_ACCRD = 12'b000000100000,
		S_ACCWR = 12'b000001000000,
		S_FRD   = 12'b000010000000,
		S_FMUL  = 12'b000100000000,
		S_FDIV  = 12'b001000000000,
		S_FCMP  = 12'b010000000000,
		S_EMIT  = 12'b100000000000
	} state_t;

	state_t state_q;

	// configuration registers
	logic [1:0]                      dim_q;
	logic [3:0]                      order_q;
	logic [dgpp_pkg::CNT_W-1:0]      count_q;

	// item registers
	dgpp_pkg::op_t                   op_q;
	logic [dgpp_pkg::IDX_W-1:0]      a_q;
	logic [dgpp_pkg::IDX_W-1:0]      b_q;
	logic [dgpp_pkg::SIZE_W-1:0]     edge_q;
	logic                            sel_q;
	logic [dgpp_pkg::ACC_W-1:0]      quot_q;
	logic [1:0]                      err_q;

	// finish walk
	logic [dgpp_pkg::IDX_W-1:0]      i_q;
	logic [dgpp_pkg::QD_W-1:0]       qd_q;
	logic [1:0]                      qrem_q;
	logic [dgpp_pkg::QD_CNT_W-1:0]   dcnt_q;
	logic [dgpp_pkg::ACC_W-1:0]      best_q;

	// output register
	logic                            out_valid_q;
	logic [dgpp_pkg::ACC_W-1:0]      penalty_q;
	logic [1:0]                      status_q;

	logic                            in_acc;
	logic [dgpp_pkg::IDX_W-1:0]      idx;
	logic [dgpp_pkg::SIZE_W-1:0]     size_rd;
	logic [dgpp_pkg::ACC_W-1:0]      acc_rd;
	logic                            acc_we;
	logic [dgpp_pkg::IDX_W-1:0]      acc_waddr;
	logic [dgpp_pkg::ACC_W-1:0]      acc_wdata;
	logic [dgpp_pkg::IDX_W-1:0]      acc_raddr;
	logic [dgpp_pkg::ACC_W:0]        sum;
	logic [dgpp_pkg::ACC_W-1:0]      sum_sat;
	logic [dgpp_pkg::ACC_W-1:0]      num_full;
	logic [dgpp_pkg::ACC_W-1:0]      dividend;
	logic                            div_start;
	dgpp_pkg::div_stat_t             div_st;
	logic [dgpp_pkg::ACC_W-1:0]      div_quot;
	logic [4:0]                      n1;
	logic [4:0]                      nd;
	logic [9:0]                      coef_full;
	logic [dgpp_pkg::MUL_W-1:0]      coef;
	logic [1:0]                      dvsr;
	logic [dgpp_pkg::PROD_W-1:0]     prod;
	logic [dgpp_pkg::QD_W-1:0]       qd_next;
	logic [1:0]                      qrem_next;
	logic [dgpp_pkg::CNT_W-1:0]      k_lim;
	logic                            v_sat;
	logic [dgpp_pkg::ACC_W-1:0]      v_val;
	logic                            in_range;
	logic                            out_free;

	function automatic logic [1:0] merge_flag(input logic [1:0] cur, input logic [1:0] code);
		merge_flag = (code > cur) ? code : cur;
	endfunction

	assign in_stall  = (state_q != S_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || !out_stall;

	assign idx = sel_q ? b_q : a_q;

	// element size store: written by loads, read by edges
	dgpp_ram #(
		.WIDTH(dgpp_pkg::SIZE_W),
		.DEPTH(dgpp_pkg::MAX_ELEMENTS)
	) u_size_ram (
		.clk   (clk),
		.we    (in_acc && (op == dgpp_pkg::OP_LOAD)),
		.waddr (elem_a),
		.wdata (size_value),
		.raddr (idx),
		.rdata (size_rd)
	);

	// accumulator store: cleared by the reset pass and by every finish walk
	dgpp_ram #(
		.WIDTH(dgpp_pkg::ACC_W),
		.DEPTH(dgpp_pkg::MAX_ELEMENTS)
	) u_acc_ram (
		.clk   (clk),
		.we    (acc_we),
		.waddr (acc_waddr),
		.wdata (acc_wdata),
		.raddr (acc_raddr),
		.rdata (acc_rd)
	);

	// saturating accumulate
	assign sum     = {1'b0, acc_rd} + {1'b0, quot_q};
	assign sum_sat = sum[dgpp_pkg::ACC_W] ? dgpp_pkg::ACC_MAX : sum[dgpp_pkg::ACC_W-1:0];

	always_comb begin
		acc_we    = 1'b0;
		acc_waddr = i_q;
		acc_wdata = '0;
		case (state_q)
			S_CLEAR: begin
				acc_we = 1'b1;
			end
			S_FMUL: begin
				acc_we = 1'b1;
			end
			S_ACCWR: begin
				acc_we    = 1'b1;
				acc_waddr = idx;
				acc_wdata = sum_sat;
			end
			default: begin
				acc_we = 1'b0;
			end
		endcase
	end

	assign acc_raddr = (state_q == S_ACCRD) ? idx : i_q;

	// an inner edge divides by twice the size: halve the shifted edge instead, exact
	assign num_full = dgpp_pkg::ACC_W'(edge_q) << dgpp_pkg::FRAC_BITS;
	assign dividend = (op_q == dgpp_pkg::OP_INNER) ? (num_full >> 1) : num_full;
	assign div_start = (state_q == S_DIVS) && (size_rd != '0);

	dgpp_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dividend),
		.divisor  (size_rd),
		.stat     (div_st),
		.quotient (div_quot)
	);

	// coefficient (N+1)(N+d) over d; dimension zero means no scaling
	assign n1        = {1'b0, order_q} + 5'd1;
	assign nd        = {1'b0, order_q} + {3'b000, dim_q};
	assign coef_full = (dim_q == 2'd0) ? 10'd1 : (10'(n1) * 10'(nd));
	assign coef      = coef_full[dgpp_pkg::MUL_W-1:0];
	assign dvsr      = (dim_q == 2'd0) ? 2'd1 : dim_q;
	assign prod      = dgpp_pkg::PROD_W'(acc_rd) * dgpp_pkg::PROD_W'(coef);

	// one 8-bit digit of the division by d per cycle
	always_comb begin
		logic [2:0] t;
		logic       qb;
		qd_next   = qd_q;
		qrem_next = qrem_q;
		for (int j = 0; j < dgpp_pkg::DIGIT_W; j++) begin
			t  = {qrem_next, qd_next[dgpp_pkg::QD_W-1]};
			qb = (t >= {1'b0, dvsr});
			if (qb) begin
				t = t - {1'b0, dvsr};
			end
			qd_next   = {qd_next[dgpp_pkg::QD_W-2:0], qb};
			qrem_next = t[1:0];
		end
	end

	assign k_lim    = (count_q > dgpp_pkg::CNT_W'(dgpp_pkg::MAX_ELEMENTS))
	                ? dgpp_pkg::CNT_W'(dgpp_pkg::MAX_ELEMENTS) : count_q;
	assign in_range = {1'b0, i_q} < k_lim;
	assign v_sat    = |qd_q[dgpp_pkg::QD_W-1:dgpp_pkg::ACC_W];
	assign v_val    = v_sat ? dgpp_pkg::ACC_MAX : qd_q[dgpp_pkg::ACC_W-1:0];

	// configuration writes; indexes past the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_q   <= 2'd2;
			order_q <= 4'd1;
			count_q <= dgpp_pkg::CNT_W'(4096);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				dgpp_pkg::CFG_DIM:   dim_q   <= cfg_data[1:0];
				dgpp_pkg::CFG_ORDER: order_q <= cfg_data[3:0];
				dgpp_pkg::CFG_COUNT: count_q <= cfg_data[dgpp_pkg::CNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// control sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			i_q         <= '0;
			sel_q       <= 1'b0;
			err_q       <= dgpp_pkg::ST_OK;
			dcnt_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// drop a taken result unless the emit step reloads the register
			if (out_valid_q && !out_stall && (state_q != S_EMIT)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					i_q <= i_q + 1'b1;
					if (i_q == dgpp_pkg::IDX_W'(dgpp_pkg::MAX_ELEMENTS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					sel_q <= 1'b0;
					i_q   <= '0;
					if (in_acc) begin
						case (op)
							dgpp_pkg::OP_INNER:    state_q <= S_RD;
							dgpp_pkg::OP_BOUNDARY: state_q <= S_RD;
							dgpp_pkg::OP_FINISH:   state_q <= S_FRD;
							default:               state_q <= S_IDLE;
						endcase
					end
				end
				S_RD: begin
					state_q <= S_DIVS;
				end
				S_DIVS: begin
					if (size_rd == '0) begin
						err_q   <= merge_flag(err_q, dgpp_pkg::ST_ZERO_SIZE);
						state_q <= S_ACCRD;
					end else begin
						state_q <= S_DIVW;
					end
				end
				S_DIVW: begin
					if (div_st.done) begin
						state_q <= S_ACCRD;
					end
				end
				S_ACCRD: begin
					state_q <= S_ACCWR;
				end
				S_ACCWR: begin
					if (sum[dgpp_pkg::ACC_W]) begin
						err_q <= merge_flag(err_q, dgpp_pkg::ST_SATURATED);
					end
					if ((op_q == dgpp_pkg::OP_INNER) && !sel_q) begin
						sel_q   <= 1'b1;
						state_q <= S_RD;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_FRD: begin
					state_q <= S_FMUL;
				end
				S_FMUL: begin
					dcnt_q  <= '0;
					state_q <= S_FDIV;
				end
				S_FDIV: begin
					dcnt_q <= dcnt_q + 1'b1;
					if (dcnt_q == dgpp_pkg::QD_CNT_W'(dgpp_pkg::QD_STEPS - 1)) begin
						state_q <= S_FCMP;
					end
				end
				S_FCMP: begin
					if (in_range && v_sat) begin
						err_q <= merge_flag(err_q, dgpp_pkg::ST_SATURATED);
					end
					i_q <= i_q + 1'b1;
					if (i_q == dgpp_pkg::IDX_W'(dgpp_pkg::MAX_ELEMENTS - 1)) begin
						state_q <= S_EMIT;
					end else begin
						state_q <= S_FRD;
					end
				end
				S_EMIT: begin
					// hold until the output register is free, then drop the flags
					if (out_free) begin
						out_valid_q <= 1'b1;
						err_q       <= dgpp_pkg::ST_OK;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_q   <= dgpp_pkg::op_t'(op);
			a_q    <= elem_a;
			b_q    <= elem_b;
			edge_q <= size_value;
			best_q <= '0;
		end
		if ((state_q == S_DIVS) && (size_rd == '0)) begin
			quot_q <= dgpp_pkg::ACC_MAX;
		end else if ((state_q == S_DIVW) && div_st.done) begin
			quot_q <= div_quot;
		end
		if (state_q == S_FMUL) begin
			qd_q   <= dgpp_pkg::QD_W'(prod);
			qrem_q <= 2'd0;
		end else if (state_q == S_FDIV) begin
			qd_q   <= qd_next;
			qrem_q <= qrem_next;
		end
		if ((state_q == S_FCMP) && in_range && (v_val >= best_q)) begin
			best_q <= v_val;
		end
		if ((state_q == S_EMIT) && out_free) begin
			penalty_q <= best_q;
			status_q  <= err_q;
		end
	end

	assign out_valid = out_valid_q;
	assign penalty   = penalty_q;
	assign status    = status_q;

	// divider finishes only while the sequencer waits for it
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_st.done |-> (state_q == S_DIVW))
		else $error("divider done outside wait state");

	// divider runs only while the sequencer waits for it
	a_div_busy: assert property (@(posedge clk) disable iff (!arst_n)
		div_st.busy |-> (state_q == S_DIVW))
		else $error("divider busy outside wait state");

	// a nonzero accumulator write comes only from an edge update
	a_acc_wr: assert property (@(posedge clk) disable iff (!arst_n)
		(acc_we && (acc_wdata != '0)) |-> (state_q == S_ACCWR))
		else $error("nonzero accumulator write outside edge update");

	// a result appears only from the emit step
	a_out_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_EMIT))
		else $error("result raised outside emit");

	// flags are clear right after a result is issued
	a_flag_clr: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_EMIT) && out_free) |=> (err_q == dgpp_pkg::ST_OK))
		else $error("flags not cleared after finish");

endmodule

[tb/sv/dg_penalty_parameter_max_top_test.sv]
module dg_penalty_parameter_max_top_test;

	// run length guard: sized for every transaction being a full finish walk under stalls
	localparam int unsigned CYCLE_LIMIT = 150000000;
	localparam int unsigned DRAIN_CYCLES = 300;
	// long enough to span two full finish walks so the second result backs up the input
	localparam int unsigned LONG_HOLD = 100000;

	typedef struct packed {
		logic [dgpp_pkg::ACC_W-1:0] penalty;
		logic [1:0]                 status;
	} penalty_result_t;

	logic                            clk;
	logic                            arst_n;
	logic                            in_valid;
	logic                            in_stall;
	logic [1:0]                      op;
	logic [11:0]                     elem_a;
	logic [11:0]                     elem_b;
	logic [31:0]                     size_value;
	logic                            out_valid;
	logic                            out_stall;
	logic [47:0]                     penalty;
	logic [1:0]                      status;
	logic                            cfg_valid;
	logic                            cfg_ready;
	logic [dgpp_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [dgpp_pkg::CFG_DATA_W-1:0] cfg_data;

	dg_penalty_parameter_max_top DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .op(op), .elem_a(elem_a),
		.elem_b(elem_b), .size_value(size_value),
		.out_valid(out_valid), .out_stall(out_stall), .penalty(penalty), .status(status),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// shadow copy of the block: sizes, accumulators, error flags and registers
	logic [dgpp_pkg::SIZE_W-1:0] size_shadow [dgpp_pkg::MAX_ELEMENTS];
	logic [dgpp_pkg::ACC_W-1:0]  acc_shadow [dgpp_pkg::MAX_ELEMENTS];
	bit                          size_known [dgpp_pkg::MAX_ELEMENTS];
	int                          known_elems [$];
	logic [1:0]                  flag_shadow;
	logic [1:0]                  dim_shadow;
	logic [3:0]                  order_shadow;
	logic [12:0]                 count_shadow;

	penalty_result_t   pending_penalties [$];

	int unsigned items_sent;
	int unsigned finishes_sent;
	int unsigned results_seen;
	int unsigned cfg_writes;
	int unsigned mismatches;
	int unsigned cycle_count;
	bit          gaps_on;
	bit          long_hold_req;

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		op = dgpp_pkg::OP_LOAD;
		elem_a = '0;
		elem_b = '0;
		size_value = '0;
		out_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = dgpp_pkg::CFG_DIM;
		cfg_data = '0;
	end

	// Timeout watchdog.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				pending_penalties.size());
			$display("dg_penalty_parameter_max_top: mismatch");
			$finish;
		end
	end

	// ---------------------------------------------------------------------
	// Predictor
	// ---------------------------------------------------------------------
	function automatic void raise_status(logic [1:0] code);
		if (code > flag_shadow)
			flag_shadow = code;
	endfunction

	// (edge << FRAC_BITS) / (size * halves), saturating at the accumulator width
	function automatic logic [dgpp_pkg::ACC_W-1:0] edge_ratio(logic [31:0] edge_len,
			logic [31:0] elem_size, int unsigned halves);
		logic [63:0] q;
		if (elem_size == '0) begin
			raise_status(dgpp_pkg::ST_ZERO_SIZE);
			return dgpp_pkg::ACC_MAX;
		end
		q = ({32'b0, edge_len} << dgpp_pkg::FRAC_BITS) / ({32'b0, elem_size} * halves);
		if (q > {16'b0, dgpp_pkg::ACC_MAX}) begin
			raise_status(dgpp_pkg::ST_SATURATED);
			return dgpp_pkg::ACC_MAX;
		end
		return q[dgpp_pkg::ACC_W-1:0];
	endfunction

	function automatic void add_to_elem(int idx, logic [dgpp_pkg::ACC_W-1:0] v);
		logic [dgpp_pkg::ACC_W:0] s;
		s = {1'b0, acc_shadow[idx]} + {1'b0, v};
		if (s[dgpp_pkg::ACC_W]) begin
			raise_status(dgpp_pkg::ST_SATURATED);
			acc_shadow[idx] = dgpp_pkg::ACC_MAX;
		end else begin
			acc_shadow[idx] = s[dgpp_pkg::ACC_W-1:0];
		end
	endfunction

	// Apply one accepted transaction; queue a result when it is a finish.
	function automatic void predict_penalty(dgpp_pkg::op_t code, logic [11:0] a,
			logic [11:0] b, logic [31:0] sz);
		logic [63:0] mul;
		logic [63:0] dv;
		logic [63:0] v;
		logic [63:0] best;
		int          lim;
		penalty_result_t r;
		case (code)
			dgpp_pkg::OP_LOAD: begin
				size_shadow[a] = sz;
				if (!size_known[a]) begin
					size_known[a] = 1'b1;
					known_elems.push_back(int'(a));
				end
			end
			dgpp_pkg::OP_INNER: begin
				add_to_elem(int'(a), edge_ratio(sz, size_shadow[a], 2));
				add_to_elem(int'(b), edge_ratio(sz, size_shadow[b], 2));
			end
			dgpp_pkg::OP_BOUNDARY: add_to_elem(int'(a), edge_ratio(sz, size_shadow[a], 1));
			default: begin
				lim = (int'(count_shadow) > dgpp_pkg::MAX_ELEMENTS) ? dgpp_pkg::MAX_ELEMENTS
					: int'(count_shadow);
				if (dim_shadow == 2'd0) begin
					mul = 64'd1;
					dv = 64'd1;
				end else begin
					mul = (64'(order_shadow) + 64'd1) * (64'(order_shadow) + 64'(dim_shadow));
					dv = 64'(dim_shadow);
				end
				best = '0;
				for (int i = 0; i < lim; i++) begin
					v = {16'b0, acc_shadow[i]} * mul / dv;
					if (v > {16'b0, dgpp_pkg::ACC_MAX}) begin
						raise_status(dgpp_pkg::ST_SATURATED);
						v = {16'b0, dgpp_pkg::ACC_MAX};
					end
					if (v >= best)
						best = v;
				end
				r.penalty = best[dgpp_pkg::ACC_W-1:0];
				r.status = flag_shadow;
				pending_penalties.push_back(r);
				for (int i = 0; i < dgpp_pkg::MAX_ELEMENTS; i++)
					acc_shadow[i] = '0;
				flag_shadow = dgpp_pkg::ST_OK;
			end
		endcase
	endfunction

	// ---------------------------------------------------------------------
	// Result checker: compare each accepted result against the oldest prediction
	// ---------------------------------------------------------------------
	always @(posedge clk) begin
		penalty_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			results_seen <= results_seen + 1;
			if (pending_penalties.size() == 0) begin
				mismatches = mismatches + 1;
				if (mismatches <= 10)
					$display("unexpected result penalty=%h status=%0d", penalty, status);
			end else begin
				want = pending_penalties.pop_front();
				if (want.penalty !== penalty || want.status !== status) begin
					mismatches = mismatches + 1;
					if (mismatches <= 10)
						$display({"result mismatch: expected penalty=%h status=%0d,",
							" got penalty=%h status=%0d"},
							want.penalty, want.status, penalty, status);
				end
			end
		end
	end

	// ---------------------------------------------------------------------
	// Result-side stall: random bursts, plus one long hold-off on request
	// ---------------------------------------------------------------------
	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (long_hold_req) begin
				out_stall <= 1'b1;
				// count the hold-off here so the sender keeps offering transactions
				repeat (LONG_HOLD) @(posedge clk);
				long_hold_req = 1'b0;
				out_stall <= 1'b0;
			end else if (gaps_on && $urandom_range(0, 3) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 14)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------------
	// Shared stimulus tasks
	// ---------------------------------------------------------------------
	// Offer one transaction, hold it until accepted, then maybe drop valid for a while.
	task automatic send_item(dgpp_pkg::op_t code, logic [11:0] a, logic [11:0] b,
			logic [31:0] sz);
		in_valid <= 1'b1;
		op <= code;
		elem_a <= a;
		elem_b <= b;
		size_value <= sz;
		do @(posedge clk); while (in_stall);
		predict_penalty(code, a, b, sz);
		items_sent++;
		if (code == dgpp_pkg::OP_FINISH)
			finishes_sent++;
		if (gaps_on && $urandom_range(0, 2) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
	endtask

	// Wait for every predicted result, then let in-flight edge work settle.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_penalties.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [dgpp_pkg::CFG_IDX_W-1:0] idx,
			logic [dgpp_pkg::CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		cfg_writes++;
		case (idx)
			dgpp_pkg::CFG_DIM:   dim_shadow = data[1:0];
			dgpp_pkg::CFG_ORDER: order_shadow = data[3:0];
			dgpp_pkg::CFG_COUNT: count_shadow = data[12:0];
			default: ;
		endcase
	endtask

	task automatic set_config(logic [1:0] dim, logic [3:0] order, logic [12:0] count);
		write_reg(dgpp_pkg::CFG_DIM, dgpp_pkg::CFG_DATA_W'(dim));
		write_reg(dgpp_pkg::CFG_ORDER, dgpp_pkg::CFG_DATA_W'(order));
		write_reg(dgpp_pkg::CFG_COUNT, dgpp_pkg::CFG_DATA_W'(count));
	endtask

	// Size with a random magnitude so small, mid and full-scale values all show up.
	function automatic logic [31:0] rand_size();
		return $urandom >> $urandom_range(0, 31);
	endfunction

	function automatic logic [11:0] pick_known();
		return 12'(known_elems[$urandom_range(0, known_elems.size() - 1)]);
	endfunction

	// One random transaction; edges only touch elements whose size has been loaded.
	task automatic send_random(int finish_odds);
		int sel;
		logic [31:0] sz;
		sel = $urandom_range(0, 99);
		if ($urandom_range(1, finish_odds) == 1) begin
			send_item(dgpp_pkg::OP_FINISH, 12'($urandom), 12'($urandom), $urandom);
		end else if (sel < 15 || known_elems.size() == 0) begin
			sz = ($urandom_range(0, 19) == 0) ? 32'd0 : rand_size();
			send_item(dgpp_pkg::OP_LOAD, 12'($urandom), 12'($urandom), sz);
		end else if (sel < 65) begin
			send_item(dgpp_pkg::OP_INNER, pick_known(), pick_known(), rand_size());
		end else begin
			send_item(dgpp_pkg::OP_BOUNDARY, pick_known(), 12'($urandom), rand_size());
		end
	endtask

	// ---------------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------------
	// Extremes of every field, every op, zero sizes, same neighbor, saturation, reset config.
	task automatic test_directed();
		send_item(dgpp_pkg::OP_LOAD, 12'd0, 12'd0, 32'd1);
		send_item(dgpp_pkg::OP_LOAD, 12'hFFF, 12'hFFF, 32'hFFFF_FFFF);
		send_item(dgpp_pkg::OP_LOAD, 12'd1, 12'd0, 32'd0);
		send_item(dgpp_pkg::OP_LOAD, 12'd2, 12'h555, 32'h0001_0000);
		send_item(dgpp_pkg::OP_INNER, 12'd0, 12'hFFF, 32'hFFFF_FFFF);
		send_item(dgpp_pkg::OP_INNER, 12'd2, 12'd2, 32'h0003_0000);
		send_item(dgpp_pkg::OP_BOUNDARY, 12'd1, 12'hAAA, 32'h0000_8000);
		send_item(dgpp_pkg::OP_BOUNDARY, 12'd2, 12'd0, 32'd0);
		send_item(dgpp_pkg::OP_FINISH, 12'd0, 12'd0, 32'd0);
		wait_idle();
		// smallest coefficient and a single element in the search
		set_config(2'd1, 4'd0, 13'd1);
		send_item(dgpp_pkg::OP_BOUNDARY, 12'd0, 12'd0, 32'h0000_0002);
		send_item(dgpp_pkg::OP_INNER, 12'd2, 12'hFFF, 32'h0002_0000);
		send_item(dgpp_pkg::OP_FINISH, 12'hFFF, 12'hFFF, 32'hFFFF_FFFF);
		wait_idle();
		// largest coefficient, count above the store depth, accumulate into saturation
		set_config(2'd3, 4'd15, 13'h1FFF);
		send_item(dgpp_pkg::OP_BOUNDARY, 12'd0, 12'd0, 32'hFFFF_FFFF);
		send_item(dgpp_pkg::OP_BOUNDARY, 12'd0, 12'd0, 32'hFFFF_FFFF);
		send_item(dgpp_pkg::OP_BOUNDARY, 12'd2, 12'd0, 32'h0001_0000);
		send_item(dgpp_pkg::OP_FINISH, 12'd0, 12'd0, 32'd0);
		wait_idle();
		// no scaling and an empty search
		set_config(2'd0, 4'd7, 13'd0);
		send_item(dgpp_pkg::OP_BOUNDARY, 12'hFFF, 12'd0, 32'h1234_5678);
		send_item(dgpp_pkg::OP_FINISH, 12'd0, 12'd0, 32'd0);
		wait_idle();
	endtask

	// Block fills while results are held back; the sender then pauses for full drain.
	task automatic test_backpressure();
		set_config(2'd2, 4'd3, 13'(dgpp_pkg::MAX_ELEMENTS));
		send_item(dgpp_pkg::OP_INNER, pick_known(), pick_known(), rand_size());
		long_hold_req = 1'b1;
		send_item(dgpp_pkg::OP_FINISH, 12'd0, 12'd0, 32'd0);
		repeat (4) send_item(dgpp_pkg::OP_BOUNDARY, pick_known(), 12'd0, rand_size());
		send_item(dgpp_pkg::OP_FINISH, 12'd0, 12'd0, 32'd0);
		wait_idle();
	endtask

	task automatic test_random();
		int unsigned start_items;
		int unsigned start_finishes;
		int unsigned c;
		start_items = items_sent;
		start_finishes = finishes_sent;
		while (items_sent - start_items < 920 || finishes_sent - start_finishes < 24) begin
			// go quiet for the tail of the run
			if (items_sent - start_items >= 840)
				gaps_on = 1'b0;
			send_random((items_sent - start_items >= 920) ? 4 : 36);
			if (pending_penalties.size() != 0 && $urandom_range(0, 2) == 0) begin
				wait_idle();
				c = $urandom_range(0, 3);
				case ($urandom_range(0, 2))
					0: write_reg(dgpp_pkg::CFG_DIM,
						dgpp_pkg::CFG_DATA_W'($urandom_range(0, 3)));
					1: write_reg(dgpp_pkg::CFG_ORDER,
						dgpp_pkg::CFG_DATA_W'($urandom_range(0, 15)));
					default: write_reg(dgpp_pkg::CFG_COUNT, (c == 0)
						? dgpp_pkg::CFG_DATA_W'(dgpp_pkg::MAX_ELEMENTS)
						: (c == 1) ? 13'h1FFF
						: dgpp_pkg::CFG_DATA_W'($urandom_range(1, dgpp_pkg::MAX_ELEMENTS)));
				endcase
			end
		end
	endtask

	initial begin
		items_sent = 0;
		finishes_sent = 0;
		results_seen = 0;
		cfg_writes = 0;
		mismatches = 0;
		cycle_count = 0;
		long_hold_req = 1'b0;
		gaps_on = 1'b1;
		flag_shadow = dgpp_pkg::ST_OK;
		dim_shadow = 2'd2;
		order_shadow = 4'd1;
		count_shadow = 13'd4096;
		for (int i = 0; i < dgpp_pkg::MAX_ELEMENTS; i++) begin
			acc_shadow[i] = '0;
			size_shadow[i] = '0;
			size_known[i] = 1'b0;
		end
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_backpressure();
		test_random();

		wait_idle();
		$display("covered %0d transactions (%0d finishes, %0d results) and %0d register writes",
			items_sent, finishes_sent, results_seen, cfg_writes);
		$display("all ops, zero sizes, saturation, count and dimension extremes, long result hold-off");
		if (mismatches == 0)
			$display("dg_penalty_parameter_max_top: match");
		else
			$display("dg_penalty_parameter_max_top: mismatch");
		$finish;
	end

endmodule
